// ----- rtl/scanline_edge_fill_collector_defines.svh -----
// Assertion macros shared by the scanline edge fill collector RTL
`ifndef SCANLINE_EDGE_FILL_COLLECTOR_DEFINES_SVH
`define SCANLINE_EDGE_FILL_COLLECTOR_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent
`define SEFC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define SEFC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/sefc_pkg.sv -----
// Shared types and constants for the scanline edge fill collector
package sefc_pkg;

  // Fixed field widths
  localparam int CW    = 12;   // input coordinates, edge table entries
  localparam int COL_W = 9;    // span_left / span_right
  localparam int ROW_W = 8;    // span_row

  // Screen geometry
  localparam int WIDTH       = 320;
  localparam int DEF_HEIGHT  = 200;

  // Input command codes
  localparam logic [1:0] CMD_BEGIN = 2'd0;
  localparam logic [1:0] CMD_HSPAN = 2'd1;
  localparam logic [1:0] CMD_VSPAN = 2'd2;
  localparam logic [1:0] CMD_DRAIN = 2'd3;

  // Datapath operation issued by the controller each cycle
  typedef enum logic [3:0] {
    OP_NONE,
    OP_CLEAR,        // write blank entry at the clear counter
    OP_BEGIN,        // mark touched range empty
    OP_HSTART,       // read row of horizontal span, widen range
    OP_HWRITE,       // write back merged horizontal span
    OP_VSTART,       // read first row of vertical run, widen range
    OP_VSTEP,        // write previous row, read next row
    OP_VLAST,        // write final row of vertical run
    OP_DRAIN_EMPTY,  // report empty range
    OP_DRAIN_READ,   // read top row of touched range
    OP_DRAIN_DONE    // report span, blank the row, advance top or empty the range after the last row
  } dp_op_t;

  // Datapath status back to the controller
  typedef struct packed {
    logic clr_last;
    logic h_onscreen;
    logic v_nonempty;
    logic v_more;
    logic range_empty;
    logic out_free;
  } dp_status_t;

  // Controller states
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_HWRITE,
    ST_VERT,
    ST_DRAIN
  } ctrl_state_t;

endpackage

// ----- rtl/sefc_ctrl.sv -----
// Controller state machine for the scanline edge fill collector
module sefc_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic [1:0]           cmd,
  input  sefc_pkg::dp_status_t status,
  output logic                 in_ready,
  output sefc_pkg::dp_op_t     op
);
  import sefc_pkg::*;

  ctrl_state_t state, state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // A drain needs the output register free; other commands never wait on it
  assign in_ready = (state == ST_IDLE) && ((cmd != CMD_DRAIN) || status.out_free);

  // Next state and datapath operation
  always_comb begin
    state_next = state;
    op         = OP_NONE;
    unique case (state)
      ST_CLEAR: begin
        op = OP_CLEAR;
        if (status.clr_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid && in_ready) begin
          unique case (cmd)
            CMD_BEGIN: op = OP_BEGIN;
            CMD_HSPAN: begin
              if (status.h_onscreen) begin
                op         = OP_HSTART;
                state_next = ST_HWRITE;
              end
            end
            CMD_VSPAN: begin
              if (status.v_nonempty) begin
                op         = OP_VSTART;
                state_next = ST_VERT;
              end
            end
            CMD_DRAIN: begin
              if (status.range_empty) begin
                op = OP_DRAIN_EMPTY;
              end else begin
                op         = OP_DRAIN_READ;
                state_next = ST_DRAIN;
              end
            end
          endcase
        end
      end
      ST_HWRITE: begin
        op         = OP_HWRITE;
        state_next = ST_IDLE;
      end
      ST_VERT: begin
        if (status.v_more) begin
          op = OP_VSTEP;
        end else begin
          op         = OP_VLAST;
          state_next = ST_IDLE;
        end
      end
      ST_DRAIN: begin
        op         = OP_DRAIN_DONE;
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

endmodule

// ----- rtl/sefc_datapath.sv -----
// Edge tables, row range tracking and output register of the fill collector
module sefc_datapath #(
  parameter int HEIGHT = sefc_pkg::DEF_HEIGHT
) (
  input  logic                                clk,
  input  logic                                rst,
  input  sefc_pkg::dp_op_t                    op,
  output sefc_pkg::dp_status_t                status,
  input  logic signed [sefc_pkg::CW-1:0]      coord_a,
  input  logic signed [sefc_pkg::CW-1:0]      coord_b,
  input  logic signed [sefc_pkg::CW-1:0]      coord_c,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [sefc_pkg::COL_W-1:0]          span_left,
  output logic [sefc_pkg::COL_W-1:0]          span_right,
  output logic [sefc_pkg::ROW_W-1:0]          span_row,
  output logic                                span_valid,
  output logic                                last
);
  import sefc_pkg::*;

  localparam int RW = $clog2(HEIGHT);   // row address
  localparam int NW = RW + 1;           // row count 0..HEIGHT

  localparam logic signed [CW-1:0] HMAX_S   = CW'(HEIGHT - 1);
  localparam logic signed [CW-1:0] HEIGHT_S = CW'(HEIGHT);
  localparam logic signed [CW-1:0] WIDTH_S  = CW'(WIDTH);
  localparam logic signed [CW-1:0] WMAX_S   = CW'(WIDTH - 1);
  localparam logic signed [CW-1:0] NONE_S   = '1;
  localparam logic [NW-1:0]        HEIGHT_N = NW'(HEIGHT);
  localparam logic [RW-1:0]        LAST_ROW = RW'(HEIGHT - 1);
  localparam logic [2*CW-1:0]      BLANK    = {WIDTH_S, NONE_S};

  // Edge table: {left, right} per row
  logic [2*CW-1:0] mem [HEIGHT];
  logic [2*CW-1:0] rd_data;
  logic [RW-1:0]   rd_row;
  logic            rd_en, wr_en;
  logic [RW-1:0]   rd_addr, wr_addr;
  logic [2*CW-1:0] wr_data;

  // Sequencing and range registers
  logic [RW-1:0]          clr_cnt;
  logic [NW-1:0]          cur_row;
  logic [RW-1:0]          end_row;
  logic [NW-1:0]          top, bot1;   // bot1 is bottom row plus one
  logic signed [CW-1:0]   xl, xr;

  // Decoded input rows
  logic signed [CW-1:0]   yt_s, yb_s;
  logic [RW-1:0]          yt_row, yb_row, h_row;

  // Merge and drain arithmetic
  logic signed [CW-1:0]   old_l, old_r, new_l, new_r, l_c, r_c;
  logic                   d_valid, d_fin;
  logic [NW-1:0]          top_inc;

  // Vertical run clamps and horizontal row check
  always_comb begin
    yt_s   = (coord_b < 0) ? '0 : coord_b;
    yb_s   = (coord_c > HMAX_S) ? HMAX_S : coord_c;
    yt_row = yt_s[RW-1:0];
    yb_row = yb_s[RW-1:0];
    h_row  = coord_c[RW-1:0];
  end

  // Status to controller
  always_comb begin
    status.clr_last    = (clr_cnt == LAST_ROW);
    status.h_onscreen  = (coord_c >= 0) && (coord_c < HEIGHT_S);
    status.v_nonempty  = (yt_s <= yb_s);
    status.v_more      = (cur_row <= {1'b0, end_row});
    status.range_empty = (top >= bot1);
    status.out_free    = !out_valid || out_ready;
  end

  // Merge of read entry with latched span, and drain clamps
  always_comb begin
    old_l   = rd_data[2*CW-1:CW];
    old_r   = rd_data[CW-1:0];
    new_l   = (old_l > xl) ? xl : old_l;
    new_r   = (old_r < xr) ? xr : old_r;
    l_c     = (old_l < 0) ? '0 : old_l;
    r_c     = (old_r > WMAX_S) ? WMAX_S : old_r;
    d_valid = (l_c <= r_c);
    top_inc = NW'(top + 1'b1);
    d_fin   = (top_inc >= bot1);
  end

  // Memory read port select
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = '0;
    unique case (op)
      OP_HSTART: begin
        rd_en   = 1'b1;
        rd_addr = h_row;
      end
      OP_VSTART: begin
        rd_en   = 1'b1;
        rd_addr = yt_row;
      end
      OP_VSTEP: begin
        rd_en   = 1'b1;
        rd_addr = cur_row[RW-1:0];
      end
      OP_DRAIN_READ: begin
        rd_en   = 1'b1;
        rd_addr = top[RW-1:0];
      end
      default: begin
        rd_en   = 1'b0;
      end
    endcase
  end

  // Memory write port select
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = rd_row;
    wr_data = {new_l, new_r};
    unique case (op)
      OP_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_cnt;
        wr_data = BLANK;
      end
      OP_HWRITE, OP_VSTEP, OP_VLAST: begin
        wr_en   = 1'b1;
      end
      OP_DRAIN_DONE: begin
        wr_en   = 1'b1;
        wr_data = BLANK;
      end
      default: begin
        wr_en   = 1'b0;
      end
    endcase
  end

  // Edge table storage, registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
      rd_row  <= rd_addr;
    end
  end

  // Span latch and vertical run counters
  always_ff @(posedge clk) begin
    if (op == OP_HSTART) begin
      xl <= coord_a;
      xr <= coord_b;
    end
    if (op == OP_VSTART) begin
      xl      <= coord_a;
      xr      <= coord_a;
      cur_row <= NW'({1'b0, yt_row} + 1'b1);
      end_row <= yb_row;
    end
    if (op == OP_VSTEP) begin
      cur_row <= NW'(cur_row + 1'b1);
    end
  end

  // Clear counter and touched row range
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
      top     <= HEIGHT_N;
      bot1    <= '0;
    end else begin
      unique case (op)
        OP_CLEAR: begin
          clr_cnt <= RW'(clr_cnt + 1'b1);
        end
        OP_BEGIN, OP_DRAIN_EMPTY: begin
          top  <= HEIGHT_N;
          bot1 <= '0;
        end
        OP_HSTART: begin
          if ({1'b0, h_row} < top) begin
            top <= {1'b0, h_row};
          end
          if (NW'({1'b0, h_row} + 1'b1) > bot1) begin
            bot1 <= NW'({1'b0, h_row} + 1'b1);
          end
        end
        OP_VSTART: begin
          if ({1'b0, yt_row} < top) begin
            top <= {1'b0, yt_row};
          end
          if (NW'({1'b0, yb_row} + 1'b1) > bot1) begin
            bot1 <= NW'({1'b0, yb_row} + 1'b1);
          end
        end
        OP_DRAIN_DONE: begin
          if (d_fin) begin
            top  <= HEIGHT_N;
            bot1 <= '0;
          end else begin
            top  <= top_inc;
          end
        end
        default: begin
          top <= top;
        end
      endcase
    end
  end

  // Output register, freed by an output transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (op == OP_DRAIN_EMPTY || op == OP_DRAIN_DONE) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (op == OP_DRAIN_EMPTY) begin
      span_left  <= '0;
      span_right <= '0;
      span_row   <= '0;
      span_valid <= 1'b0;
      last       <= 1'b1;
    end else if (op == OP_DRAIN_DONE) begin
      span_left  <= d_valid ? COL_W'(l_c) : '0;
      span_right <= d_valid ? COL_W'(r_c) : '0;
      span_row   <= ROW_W'(top);
      span_valid <= d_valid;
      last       <= d_fin;
    end
  end

endmodule

// ----- rtl/scanline_edge_fill_collector.sv -----
// Top level of the scanline edge fill collector
//
// Input channel (in_valid/in_ready) takes one command per transfer: begin
// fill, horizontal span, vertical run or drain one row, with three signed
// coordinates. Output channel (out_valid/out_ready) gives one span result
// per drain command and nothing for the others.
// Per item: a horizontal span does one read-modify-write of the edge table,
// none when its row is off screen; a vertical run goes one edge table row
// per cycle through the single read and write port, none when nothing is
// left after clamping; a drain reads the top row, none for an empty range.
// A drain result is loaded into the output register at the edge after its
// transfer (at the transfer edge itself for an empty range).
// After reset the block sweeps the edge table to blank, one row per cycle,
// with in_ready low; the row range starts empty.
// While a result waits for out_ready the block keeps taking non-drain
// commands; a drain waits until the output register is free.
`include "scanline_edge_fill_collector_defines.svh"

module scanline_edge_fill_collector #(
  parameter int HEIGHT = sefc_pkg::DEF_HEIGHT
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [1:0]                      cmd,
  input  logic signed [sefc_pkg::CW-1:0]  coord_a,
  input  logic signed [sefc_pkg::CW-1:0]  coord_b,
  input  logic signed [sefc_pkg::CW-1:0]  coord_c,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [sefc_pkg::COL_W-1:0]      span_left,
  output logic [sefc_pkg::COL_W-1:0]      span_right,
  output logic [sefc_pkg::ROW_W-1:0]      span_row,
  output logic                            span_valid,
  output logic                            last
);
  import sefc_pkg::*;

  dp_op_t     op;
  dp_status_t status;

  // Controller
  sefc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .cmd      (cmd),
    .status   (status),
    .in_ready (in_ready),
    .op       (op)
  );

  // Datapath
  sefc_datapath #(
    .HEIGHT (HEIGHT)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .op         (op),
    .status     (status),
    .coord_a    (coord_a),
    .coord_b    (coord_b),
    .coord_c    (coord_c),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .span_left  (span_left),
    .span_right (span_right),
    .span_row   (span_row),
    .span_valid (span_valid),
    .last       (last)
  );

  // Checks
  `SEFC_ASSERT_NOW(a_no_accept_in_clear, op == OP_CLEAR, !in_ready, "transfer during clear")
  `SEFC_ASSERT_NEXT(a_hspan_writes_back, op == OP_HSTART, op == OP_HWRITE, "no write-back")
  `SEFC_ASSERT_NOW(a_drain_needs_slot,
                   in_valid && in_ready && (cmd == CMD_DRAIN),
                   !out_valid || out_ready, "drain with output busy")
  `SEFC_ASSERT_NOW(a_result_from_drain, $rose(out_valid),
                   ($past(op) == OP_DRAIN_DONE) || ($past(op) == OP_DRAIN_EMPTY),
                   "result without drain")

endmodule
